// ----- rtl/four_channel_pwm_counter_bank_assert.svh -----
// Assertion macros shared by the PWM counter bank modules.
// Expects clk and rst (synchronous, active high) in the using module.
`ifndef FOUR_CHANNEL_PWM_COUNTER_BANK_ASSERT_SVH
`define FOUR_CHANNEL_PWM_COUNTER_BANK_ASSERT_SVH

// Checked only outside reset.
`define FCPWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define FCPWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/fcpwm_pkg.sv -----
// Shared types and constants for the four-channel PWM counter bank.
// No dependencies; used by every module of the block.
package fcpwm_pkg;

  localparam int CHANNELS    = 4;
  localparam int COUNT_WIDTH = 32;
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_RO = 2'd2;

  localparam logic [3:0] REG_CTRL   = 4'h0;
  localparam logic [3:0] REG_PERIOD = 4'h4;
  localparam logic [3:0] REG_DUTY   = 4'h8;
  localparam logic [3:0] REG_COUNT  = 4'hC;

  localparam int CTRL_EN_BIT = 0;
  localparam int CTRL_IE_BIT = 2;
  localparam int DONE_LSB    = 4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] address;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic [1:0]  access_status;
  } out_t;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

// ----- rtl/fcpwm_ctrl.sv -----
// Handshake controller: tracks the result register and issues execute commands.
// Depends on fcpwm_pkg and the assertion macro header.
`include "four_channel_pwm_counter_bank_assert.svh"

module fcpwm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output fcpwm_pkg::cmd_t   cmd
);

  typedef enum logic {EMPTY, FULL} state_t;

  state_t state;
  state_t state_next;

  // Take a new item when the result slot is free or is being drained now.
  assign in_stall  = (state == FULL) && out_stall;
  assign cmd.exec  = in_valid && !in_stall;
  assign out_valid = (state == FULL);

  always_comb begin
    state_next = state;
    case (state)
      EMPTY: begin
        if (cmd.exec) state_next = FULL;
      end
      FULL: begin
        if (cmd.exec) state_next = FULL;
        else if (!out_stall) state_next = EMPTY;
      end
      default: state_next = EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EMPTY;
    end else begin
      state <= state_next;
    end
  end

  `FCPWM_ASSERT(a_exec_fills, cmd.exec |=> out_valid, "executed item produced no result")
  `FCPWM_ASSERT(a_drain, (out_valid && !out_stall && !in_valid) |=> !out_valid,
                "result slot not freed after transfer")
  `FCPWM_ASSERT_ALWAYS(a_no_overwrite, !(cmd.exec && out_valid && out_stall),
                       "pending result overwritten")

endmodule

// ----- rtl/fcpwm_datapath.sv -----
// Register file, tick counters, address decode and result register.
// Depends on fcpwm_pkg and the assertion macro header.
`include "four_channel_pwm_counter_bank_assert.svh"

module fcpwm_datapath (
  input  logic            clk,
  input  logic            rst,
  input  fcpwm_pkg::cmd_t cmd,
  input  fcpwm_pkg::in_t  in_data,
  output fcpwm_pkg::out_t res
);

  localparam int CW = fcpwm_pkg::COUNT_WIDTH;
  localparam int NC = fcpwm_pkg::CHANNELS;

  logic [2:0]    ctrl        [NC];
  logic [CW-1:0] period      [NC];
  logic [CW-1:0] duty        [NC];
  logic [CW-1:0] count       [NC];
  logic [NC-1:0] done;

  logic [2:0]    ctrl_next   [NC];
  logic [CW-1:0] period_next [NC];
  logic [CW-1:0] duty_next   [NC];
  logic [CW-1:0] count_next  [NC];
  logic [NC-1:0] done_next;

  logic [7:0]                    slot;
  logic [3:0]                    reg_ofs;
  logic [fcpwm_pkg::CH_IDX_W-1:0] ch;
  logic                          is_global;
  logic                          chan_ok;
  logic [31:0]                   rdata;
  logic [1:0]                    status;
  logic                          irq_next;
  logic                          irq_now;

  // Channel n lives at 0x10 + n*0x10: the upper address nibbles select slot n+1.
  assign slot      = in_data.address[11:4];
  assign reg_ofs   = in_data.address[3:0];
  assign ch        = fcpwm_pkg::CH_IDX_W'(slot - 8'd1);
  assign is_global = (in_data.address == 12'd0);
  assign chan_ok   = (slot != 8'd0) && (32'(slot) <= NC) && (reg_ofs[1:0] == 2'b00);

  always_comb begin
    ctrl_next   = ctrl;
    period_next = period;
    duty_next   = duty;
    count_next  = count;
    done_next   = done;
    rdata       = '0;
    status      = fcpwm_pkg::ST_OK;
    case (in_data.opcode)
      fcpwm_pkg::OP_TICK: begin
        for (int n = 0; n < NC; n++) begin
          if (ctrl[n][fcpwm_pkg::CTRL_EN_BIT] && (period[n] != '0)) begin
            // Wrap also when a lowered period left the count above it.
            if (count[n] >= period[n]) begin
              count_next[n] = '0;
              done_next[n]  = 1'b1;
            end else begin
              count_next[n] = CW'(count[n] + 1'b1);
            end
          end
        end
      end
      fcpwm_pkg::OP_READ: begin
        if (is_global) begin
          for (int n = 0; n < NC; n++) begin
            rdata[n]                       = ctrl[n][fcpwm_pkg::CTRL_EN_BIT];
            rdata[fcpwm_pkg::DONE_LSB + n] = done[n];
          end
        end else if (chan_ok) begin
          case (reg_ofs)
            fcpwm_pkg::REG_CTRL:   rdata = 32'(ctrl[ch]);
            fcpwm_pkg::REG_PERIOD: rdata = 32'(period[ch]);
            fcpwm_pkg::REG_DUTY:   rdata = 32'(duty[ch]);
            default:               rdata = 32'(count[ch]);
          endcase
        end else begin
          status = fcpwm_pkg::ST_BAD;
        end
      end
      fcpwm_pkg::OP_WRITE: begin
        if (is_global) begin
          // Write one to clear done bits.
          for (int n = 0; n < NC; n++) begin
            done_next[n] = done[n] & ~in_data.write_data[fcpwm_pkg::DONE_LSB + n];
          end
        end else if (chan_ok) begin
          case (reg_ofs)
            fcpwm_pkg::REG_CTRL:   ctrl_next[ch]   = in_data.write_data[2:0];
            fcpwm_pkg::REG_PERIOD: period_next[ch] = in_data.write_data[CW-1:0];
            fcpwm_pkg::REG_DUTY:   duty_next[ch]   = in_data.write_data[CW-1:0];
            default:               status          = fcpwm_pkg::ST_RO;
          endcase
        end else begin
          status = fcpwm_pkg::ST_BAD;
        end
      end
      default: ;
    endcase

    irq_next = 1'b0;
    irq_now  = 1'b0;
    for (int n = 0; n < NC; n++) begin
      irq_next = irq_next | (ctrl_next[n][fcpwm_pkg::CTRL_IE_BIT] & done_next[n]);
      irq_now  = irq_now  | (ctrl[n][fcpwm_pkg::CTRL_IE_BIT] & done[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NC; n++) begin
        ctrl[n]   <= '0;
        period[n] <= '0;
        duty[n]   <= '0;
        count[n]  <= '0;
      end
      done <= '0;
    end else if (cmd.exec) begin
      ctrl   <= ctrl_next;
      period <= period_next;
      duty   <= duty_next;
      count  <= count_next;
      done   <= done_next;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res.read_data     <= rdata;
      res.irq_level     <= irq_next;
      res.access_status <= status;
    end
  end

  `FCPWM_ASSERT(a_irq_matches_state, cmd.exec |=> (res.irq_level == irq_now),
                "interrupt level disagrees with enable and done state")
  `FCPWM_ASSERT(a_count_read_only,
                (cmd.exec && in_data.opcode == fcpwm_pkg::OP_WRITE && chan_ok &&
                 reg_ofs == fcpwm_pkg::REG_COUNT) |=> (res.access_status == fcpwm_pkg::ST_RO),
                "count write not flagged read-only")
  `FCPWM_ASSERT(a_nonread_zero,
                (cmd.exec && in_data.opcode != fcpwm_pkg::OP_READ) |=> (res.read_data == '0),
                "nonzero read data on tick or write")

endmodule

// ----- rtl/four_channel_pwm_counter_bank.sv -----
// Top level of the four-channel PWM counter bank.
// Depends on fcpwm_pkg, fcpwm_ctrl and fcpwm_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one item per
//   transfer: a tick, a register read or a register write. Output channel
//   (out_valid / out_stall / out_data) returns exactly one result per item:
//   read data, the interrupt level after the item, and an access status.
//   The result is valid in the cycle after the input transfer.
//   Throughput: one item per cycle while the receiver does not stall; every
//   item is executed by the datapath register-file update, and the result
//   register is refilled in the same cycle it is drained.
//   When the receiver stalls, the pending result holds and in_stall rises, so
//   at most one result waits; the input side resumes as soon as it drains.
//   Reset (rst, synchronous) clears all channel registers, counts and done
//   bits and empties the result register.
//   Duty and polarity are stored and read back only.
module four_channel_pwm_counter_bank (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  fcpwm_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fcpwm_pkg::out_t out_data
);

  fcpwm_pkg::cmd_t cmd;

  fcpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fcpwm_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_data (in_data),
    .res     (out_data)
  );

endmodule

// ----- bench/pwm_bank_check_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the PWM counter bank: mirrors registers, counts and done bits.
// Depends on fcpwm_pkg for the transfer types, opcodes and register offsets.
package pwm_bank_check_pkg;
  import fcpwm_pkg::*;

  localparam logic [11:0] GLOBAL_ADDR = 12'h000;
  localparam int CH_BASE = 'h10;
  localparam int CH_STRIDE = 'h10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class pwm_bank_mirror;
    logic [2:0] ctrl_bits[CHANNELS];
    logic [COUNT_WIDTH-1:0] period_val[CHANNELS];
    logic [COUNT_WIDTH-1:0] duty_val[CHANNELS];
    logic [COUNT_WIDTH-1:0] count_val[CHANNELS];
    logic [CHANNELS-1:0] done_bits;
    out_t reply_queue[$];
    int unsigned mismatches;

    function new();
      foreach (ctrl_bits[n]) begin
        ctrl_bits[n] = '0;
        period_val[n] = '0;
        duty_val[n] = '0;
        count_val[n] = '0;
      end
      done_bits = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted input transfer and queue the reply it should produce.
    function void note_transfer(in_t item);
      out_t reply;
      int ch;
      int addr;
      logic [3:0] offset;
      bit in_bank;
      reply = '0;
      addr = int'(item.address);
      offset = item.address[3:0];
      ch = (addr - CH_BASE) / CH_STRIDE;
      in_bank = addr >= CH_BASE && addr < CH_BASE + CHANNELS * CH_STRIDE &&
                (offset == REG_CTRL || offset == REG_PERIOD ||
                 offset == REG_DUTY || offset == REG_COUNT);
      case (item.opcode)
        OP_TICK: begin
          for (int n = 0; n < CHANNELS; n++) begin
            if (ctrl_bits[n][CTRL_EN_BIT] && period_val[n] != '0) begin
              // wrap also covers a count left above a lowered period
              if (count_val[n] >= period_val[n]) begin
                count_val[n] = '0;
                done_bits[n] = 1'b1;
              end else begin
                count_val[n] = count_val[n] + 1'b1;
              end
            end
          end
        end
        OP_READ: begin
          if (item.address == GLOBAL_ADDR) begin
            for (int n = 0; n < CHANNELS; n++)
              reply.read_data[n] = ctrl_bits[n][CTRL_EN_BIT];
            reply.read_data[DONE_LSB +: CHANNELS] = done_bits;
          end else if (in_bank) begin
            case (offset)
              REG_CTRL:   reply.read_data = 32'(ctrl_bits[ch]);
              REG_PERIOD: reply.read_data = 32'(period_val[ch]);
              REG_DUTY:   reply.read_data = 32'(duty_val[ch]);
              default:    reply.read_data = 32'(count_val[ch]);
            endcase
          end else begin
            reply.access_status = ST_BAD;
          end
        end
        OP_WRITE: begin
          if (item.address == GLOBAL_ADDR) begin
            done_bits &= ~item.write_data[DONE_LSB +: CHANNELS];
          end else if (in_bank) begin
            case (offset)
              REG_CTRL:   ctrl_bits[ch] = item.write_data[2:0];
              REG_PERIOD: period_val[ch] = item.write_data[COUNT_WIDTH-1:0];
              REG_DUTY:   duty_val[ch] = item.write_data[COUNT_WIDTH-1:0];
              default:    reply.access_status = ST_RO;
            endcase
          end else begin
            reply.access_status = ST_BAD;
          end
        end
        default: ;
      endcase
      for (int n = 0; n < CHANNELS; n++)
        if (ctrl_bits[n][CTRL_IE_BIT] && done_bits[n]) reply.irq_level = 1'b1;
      reply_queue.push_back(reply);
    endfunction

    function void check_reply(out_t got);
      out_t want;
      if (reply_queue.size() == 0) begin
        $display("%0t: reply with none awaited: read_data %h irq %b status %0d",
                 $time, got.read_data, got.irq_level, got.access_status);
        mismatches++;
        return;
      end
      want = reply_queue.pop_front();
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %h, got %h", $time, want.read_data, got.read_data);
        mismatches++;
      end
      if (got.irq_level !== want.irq_level) begin
        $display("%0t: irq_level expected %b, got %b", $time, want.irq_level, got.irq_level);
        mismatches++;
      end
      if (got.access_status !== want.access_status) begin
        $display("%0t: access_status expected %0d, got %0d",
                 $time, want.access_status, got.access_status);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- bench/four_channel_pwm_counter_bank_test.sv -----
`timescale 1ns / 100ps
// Top-level bench for the PWM counter bank: directed and random bus items, random stalls.
// Depends on fcpwm_pkg, pwm_bank_check_pkg and the four_channel_pwm_counter_bank RTL.
module four_channel_pwm_counter_bank_test;
  import fcpwm_pkg::*;
  import pwm_bank_check_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1700;
  localparam logic [3:0] REG_OFFSETS[4] = '{REG_CTRL, REG_PERIOD, REG_DUTY, REG_COUNT};

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  pwm_bank_mirror mirror = new();
  int replies_seen = 0;
  bit steady_stretch = 1'b0;

  four_channel_pwm_counter_bank u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [11:0] reg_addr(int ch, logic [3:0] offset);
    return 12'(CH_BASE + ch * CH_STRIDE) + offset;
  endfunction

  // Offer one item after an optional random gap and hold it until the transfer.
  task automatic send_item(input in_t item);
    int gap;
    int pick;
    gap = 0;
    if (!steady_stretch) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) gap = $urandom_range(6, 30);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    mirror.note_transfer(item);
  endtask

  initial begin : stimulus
    in_t item;
    int pick;
    logic [3:0] offset;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: wrap, done and irq, lowered period, bad offsets, read-only count
    send_item('{OP_READ, GLOBAL_ADDR, 32'h0000_0000});
    send_item('{OP_WRITE, reg_addr(0, REG_CTRL), 32'hFFFF_FFFF});
    send_item('{OP_READ, reg_addr(0, REG_CTRL), 32'hFFFF_FFFF});
    send_item('{OP_WRITE, reg_addr(0, REG_PERIOD), 32'h0000_0002});
    repeat (3) send_item('{OP_TICK, 12'h000, 32'h0000_0000});
    send_item('{OP_READ, GLOBAL_ADDR, 32'h0000_0000});
    send_item('{OP_WRITE, reg_addr(0, REG_COUNT), 32'h0000_0005});
    repeat (2) send_item('{OP_TICK, 12'hFFF, 32'hFFFF_FFFF});
    send_item('{OP_WRITE, reg_addr(0, REG_PERIOD), 32'h0000_0001});
    send_item('{OP_TICK, 12'h000, 32'h0000_0000});
    send_item('{OP_READ, reg_addr(0, REG_COUNT), 32'h0000_0000});
    send_item('{OP_WRITE, GLOBAL_ADDR, 32'hFFFF_FFFF});
    send_item('{OP_WRITE, reg_addr(3, REG_PERIOD), 32'hFFFF_FFFF});
    send_item('{OP_READ, reg_addr(3, REG_PERIOD), 32'h0000_0000});
    send_item('{OP_WRITE, reg_addr(3, REG_DUTY), 32'hFFFF_FFFF});
    send_item('{OP_READ, reg_addr(3, REG_DUTY), 32'h0000_0000});
    send_item('{OP_READ, 12'h011, 32'h0000_0000});
    send_item('{OP_WRITE, 12'h050, 32'hFFFF_FFFF});
    send_item('{OP_READ, 12'hFFF, 32'h0000_0000});
    send_item('{OP_READ, 12'h004, 32'h0000_0000});
    send_item('{OP_UNUSED, reg_addr(0, REG_CTRL), 32'hFFFF_FFFF});
    send_item('{OP_WRITE, reg_addr(1, REG_CTRL), 32'h0000_0001});
    send_item('{OP_TICK, 12'h000, 32'h0000_0000});
    send_item('{OP_READ, reg_addr(1, REG_COUNT), 32'h0000_0000});

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_stretch = (i >= 700 && i < 1000);
      item.write_data = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 45) item.opcode = OP_TICK;
      else if (pick < 70) item.opcode = OP_READ;
      else if (pick < 98) item.opcode = OP_WRITE;
      else item.opcode = OP_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        item.address = 12'($urandom_range(0, 4095));
      end else if (pick < 30) begin
        item.address = GLOBAL_ADDR;
      end else begin
        offset = REG_OFFSETS[$urandom_range(0, 3)];
        item.address = reg_addr($urandom_range(0, CHANNELS - 1), offset);
        // keep most periods short so wraps and done bits happen often
        if (offset == REG_PERIOD && $urandom_range(0, 15) != 0)
          item.write_data = $urandom_range(0, 12);
      end
      send_item(item);
    end
    in_valid <= 1'b0;

    while (mirror.reply_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : reply_sink
    int stall_left;
    bit pressure_done;
    stall_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        mirror.check_reply(out_data);
        replies_seen++;
      end
      if (stall_left == 0) begin
        // one long hold so the result register fills and the input backs up
        if (!pressure_done && replies_seen >= 400) begin
          stall_left = 150;
          pressure_done = 1'b1;
        end else if (!(replies_seen >= 700 && replies_seen < 1000) &&
                     $urandom_range(0, 99) < 20) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(1, 3);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
